### hw/rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

### hw/rtl/hat_pkg.sv
`default_nettype none
package hat_pkg;

    typedef enum logic [1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_CALLOC  = 2'd1,
        FUNC_REALLOC = 2'd2,
        FUNC_FREE    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_TRACKED = 2'd0,
        ST_FULL    = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_NULL    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_FIND,
        S_CLEAR,
        S_FREE_SCAN,
        S_FREE_WAIT,
        S_COMMIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic scan_start;
        logic scan_step;
        logic find_hit;
        logic clear_hit;
        logic commit;
        logic out_valid;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       new_null;
        logic       old_null;
        logic       scan_last;
        logic       match;
        logic       hit;
        logic       out_taken;
    } sts_t;

endpackage
`default_nettype wire

### hw/rtl/hat_if.sv
`default_nettype none
interface hat_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [63:0] old_addr;
    logic [63:0] new_addr;
    logic [31:0] req_bytes;
    logic [31:0] elem_count;
    modport source (output valid, func, old_addr, new_addr, req_bytes, elem_count,
                    input ready);
    modport sink (input valid, func, old_addr, new_addr, req_bytes, elem_count,
                  output ready);
endinterface

interface hat_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  slot;
    logic [63:0] live_bytes;
    logic [63:0] peak_live_bytes;
    logic [31:0] alloc_events;
    logic [31:0] free_events;
    logic [31:0] realloc_events;
    logic [63:0] bytes_ever_allocated;
    logic [63:0] bytes_ever_freed;
    logic [31:0] peak_live_allocs;
    modport source (output valid, status, slot, live_bytes, peak_live_bytes, alloc_events,
                    free_events, realloc_events, bytes_ever_allocated, bytes_ever_freed,
                    peak_live_allocs, input ready);
    modport sink (input valid, status, slot, live_bytes, peak_live_bytes, alloc_events,
                  free_events, realloc_events, bytes_ever_allocated, bytes_ever_freed,
                  peak_live_allocs, output ready);
endinterface
`default_nettype wire

### hw/rtl/hat_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module hat_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output hat_pkg::cmd_t     cmd,
    input  wire hat_pkg::sts_t sts
);
    hat_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hat_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hat_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = hat_pkg::S_MUL;
                end
            end
            hat_pkg::S_MUL:
            begin
                if (sts.func == hat_pkg::FUNC_FREE)
                begin
                    state_next = sts.old_null ? hat_pkg::S_OUT : hat_pkg::S_FREE_SCAN;
                end
                else if (sts.new_null)
                begin
                    state_next = hat_pkg::S_OUT;
                end
                else if (sts.func == hat_pkg::FUNC_REALLOC)
                begin
                    state_next = hat_pkg::S_FREE_SCAN;
                end
                else
                begin
                    state_next = hat_pkg::S_FIND;
                end
            end
            hat_pkg::S_FREE_SCAN: state_next = hat_pkg::S_FREE_WAIT;
            hat_pkg::S_FREE_WAIT:
            begin
                if (sts.hit)
                begin
                    state_next = hat_pkg::S_CLEAR;
                end
                else if (sts.scan_last)
                begin
                    state_next = (sts.func == hat_pkg::FUNC_FREE) ? hat_pkg::S_COMMIT
                                                                   : hat_pkg::S_FIND;
                end
                else
                begin
                    state_next = hat_pkg::S_FREE_SCAN;
                end
            end
            hat_pkg::S_CLEAR:
            begin
                state_next = (sts.func == hat_pkg::FUNC_FREE) ? hat_pkg::S_COMMIT
                                                               : hat_pkg::S_FIND;
            end
            hat_pkg::S_FIND:
            begin
                if (sts.match || sts.scan_last)
                begin
                    state_next = hat_pkg::S_COMMIT;
                end
            end
            hat_pkg::S_COMMIT: state_next = hat_pkg::S_OUT;
            hat_pkg::S_OUT:
            begin
                if (sts.out_taken)
                begin
                    state_next = hat_pkg::S_IDLE;
                end
            end
            default: state_next = hat_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            hat_pkg::S_IDLE: cmd.load = in_valid;
            hat_pkg::S_MUL:
            begin
                cmd.mul = 1'b1;
                cmd.scan_start = 1'b1;
            end
            hat_pkg::S_FREE_SCAN: ;
            hat_pkg::S_FREE_WAIT:
            begin
                cmd.scan_step = !sts.hit && !sts.scan_last;
                cmd.scan_start = !sts.hit && sts.scan_last;
            end
            hat_pkg::S_CLEAR:
            begin
                cmd.clear_hit = 1'b1;
                cmd.scan_start = 1'b1;
            end
            hat_pkg::S_FIND:
            begin
                cmd.find_hit = sts.match;
                cmd.scan_step = !sts.match && !sts.scan_last;
            end
            hat_pkg::S_COMMIT: cmd.commit = 1'b1;
            hat_pkg::S_OUT: cmd.out_valid = 1'b1;
            default: cmd = '0;
        endcase
    end

    `ASSERT_NEXT(a_out_hold, clk, rst_n,
        state_reg == hat_pkg::S_OUT && !sts.out_taken, state_reg == hat_pkg::S_OUT)
    `ASSERT_IMPLIES(a_one_cmd, clk, rst_n, 1'b1,
        $onehot0({cmd.load, cmd.commit, cmd.out_valid, cmd.clear_hit}))
    `ASSERT_NEXT(a_commit_out, clk, rst_n, cmd.commit, state_reg == hat_pkg::S_OUT)
endmodule
`default_nettype wire

### hw/rtl/hat_dp.sv
`default_nettype none
module hat_dp #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire hat_pkg::cmd_t cmd,
    output hat_pkg::sts_t      sts,
    hat_in_if.sink             in_ch,
    hat_out_if.source          out_ch
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [63:0] addr_mem [TABLE_DEPTH];
    logic [63:0] bytes_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] live_reg;

    logic [1:0]  func_reg;
    logic [63:0] old_reg, new_reg, size_reg, old_bytes_reg;
    logic [31:0] req_reg, cnt_reg;
    logic [IW-1:0] idx_reg, hit_reg;
    logic [IW-1:0] rd_idx_reg;
    logic [63:0] rd_addr_reg, rd_bytes_reg;
    logic        found_reg;
    logic [63:0] live_tot_reg, peak_tot_reg, sum_alloc_reg, sum_free_reg;
    logic [31:0] n_alloc_reg, n_free_reg, n_realloc_reg, n_peak_reg;
    logic [1:0]  status_reg;
    logic [7:0]  slot_reg;

    logic        rd_live;
    logic [63:0] live_next, delta;
    logic [31:0] n_alloc_next, outst;
    logic        last;

    assign last = (idx_reg == IW'(TABLE_DEPTH - 1));
    assign rd_live = live_reg[rd_idx_reg];

    always_comb
    begin
        sts.func = func_reg;
        sts.new_null = (new_reg == 64'd0);
        sts.old_null = (old_reg == 64'd0);
        sts.scan_last = last;
        sts.out_taken = out_ch.ready;
        // free slot for an insert, live address match for a lookup
        sts.match = !live_reg[idx_reg];
        sts.hit = rd_live && (rd_addr_reg == old_reg) && !found_reg;
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= addr_mem[idx_reg];
        rd_bytes_reg <= bytes_mem[idx_reg];
        rd_idx_reg <= idx_reg;
        if (cmd.find_hit)
        begin
            addr_mem[idx_reg] <= new_reg;
            bytes_mem[idx_reg] <= size_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= in_ch.func;
            old_reg <= in_ch.old_addr;
            new_reg <= in_ch.new_addr;
            req_reg <= in_ch.req_bytes;
            cnt_reg <= in_ch.elem_count;
        end
        if (cmd.mul)
        begin
            size_reg <= (func_reg == hat_pkg::FUNC_CALLOC) ? 64'(req_reg) * 64'(cnt_reg)
                                                            : {32'd0, req_reg};
            old_bytes_reg <= '0;
        end
        if (cmd.clear_hit)
        begin
            old_bytes_reg <= rd_bytes_reg;
            hit_reg <= rd_idx_reg;
        end
    end

    assign n_alloc_next = n_alloc_reg + 32'd1;
    assign outst = n_alloc_next - n_free_reg;

    always_comb
    begin
        delta = size_reg - old_bytes_reg;
        if (func_reg == hat_pkg::FUNC_FREE)
        begin
            live_next = live_tot_reg - old_bytes_reg;
        end
        else
        begin
            live_next = live_tot_reg + delta;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
            idx_reg <= '0;
            found_reg <= 1'b0;
            live_tot_reg <= '0;
            peak_tot_reg <= '0;
            sum_alloc_reg <= '0;
            sum_free_reg <= '0;
            n_alloc_reg <= '0;
            n_free_reg <= '0;
            n_realloc_reg <= '0;
            n_peak_reg <= '0;
            status_reg <= hat_pkg::ST_NULL;
            slot_reg <= '0;
        end
        else
        begin
            if (cmd.mul)
            begin
                found_reg <= 1'b0;
                status_reg <= hat_pkg::ST_NULL;
                slot_reg <= '0;
            end
            if (cmd.scan_start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (cmd.clear_hit)
            begin
                live_reg[rd_idx_reg] <= 1'b0;
                found_reg <= 1'b1;
            end
            if (cmd.find_hit)
            begin
                live_reg[idx_reg] <= 1'b1;
                found_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                live_tot_reg <= live_next;
                if (func_reg == hat_pkg::FUNC_FREE)
                begin
                    n_free_reg <= n_free_reg + 32'd1;
                    sum_free_reg <= sum_free_reg + old_bytes_reg;
                    status_reg <= found_reg ? hat_pkg::ST_TRACKED : hat_pkg::ST_UNKNOWN;
                    slot_reg <= found_reg ? 8'(hit_reg) : 8'd0;
                end
                else
                begin
                    status_reg <= found_reg ? hat_pkg::ST_TRACKED : hat_pkg::ST_FULL;
                    slot_reg <= found_reg ? 8'(idx_reg) : 8'd0;
                    sum_alloc_reg <= sum_alloc_reg + size_reg;
                    if (live_next > peak_tot_reg)
                    begin
                        peak_tot_reg <= live_next;
                    end
                    if (func_reg == hat_pkg::FUNC_REALLOC)
                    begin
                        n_realloc_reg <= n_realloc_reg + 32'd1;
                    end
                    else
                    begin
                        n_alloc_reg <= n_alloc_next;
                        if (func_reg == hat_pkg::FUNC_ALLOC && outst > n_peak_reg)
                        begin
                            n_peak_reg <= outst;
                        end
                    end
                end
            end
        end
    end

    assign in_ch.ready = cmd.load;
    assign out_ch.valid = cmd.out_valid;
    assign out_ch.status = status_reg;
    assign out_ch.slot = slot_reg;
    assign out_ch.live_bytes = live_tot_reg;
    assign out_ch.peak_live_bytes = peak_tot_reg;
    assign out_ch.alloc_events = n_alloc_reg;
    assign out_ch.free_events = n_free_reg;
    assign out_ch.realloc_events = n_realloc_reg;
    assign out_ch.bytes_ever_allocated = sum_alloc_reg;
    assign out_ch.bytes_ever_freed = sum_free_reg;
    assign out_ch.peak_live_allocs = n_peak_reg;
endmodule
`default_nettype wire

### hw/rtl/heap_allocation_tracker_top.sv
`default_nettype none
// Allocation tracker: one event in, one result beat out. Each event passes
// through its control states plus one table scan per lookup: a free or
// reallocate walks the table until the old address is found, and an insert
// walks it to the lowest free slot. Each entry step of a free or reallocate
// waits on the registered read of the entry table, so it passes through the
// S_FREE_SCAN and S_FREE_WAIT states. No clearing pass is needed after reset.
// The next event is accepted once the result beat has been taken.
module heap_allocation_tracker_top #(
    parameter int TABLE_DEPTH = 256
) (
    input wire logic  clk,
    input wire logic  rst_n,
    hat_in_if.sink    in_ch,
    hat_out_if.source out_ch
);
    hat_pkg::cmd_t cmd;
    hat_pkg::sts_t sts;

    hat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .cmd      (cmd),
        .sts      (sts)
    );

    hat_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );
endmodule
`default_nettype wire
